[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands; they expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_SYNC(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: %m");

// implication form
`define ASSERT_IMPL(label, pre, post) \
  `ASSERT_SYNC(label, (pre) |-> (post))

`endif

[rtl/mrm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrm_pkg
// Types, widths and constants of the motion roughness monitor.
// ---------------------------------------------------------------------------
package mrm_pkg;

  localparam int DISTANCE_BITS_DEF = 32;
  localparam int DELAY_BITS_DEF    = 16;

  localparam int FRAC_BITS = 16;
  localparam int TIME_W    = 32;
  localparam int ROUGH_W   = 63;
  localparam int SPEED_W   = 48;
  localparam int ACCEL_W   = 64;

  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_TIME_LIMIT  = 1'b0;
  localparam logic REG_ROUGH_LIMIT = 1'b1;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [TIME_W-1:0]  TIME_LIMIT_RST  = 32'd5000000;
  localparam logic [ROUGH_W-1:0] ROUGH_LIMIT_RST = 63'd42949672960;
  localparam logic [TIME_W-1:0]  TIME_MAX        = '1;
  localparam logic [ROUGH_W-1:0] ROUGH_MAX       = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX       = {1'b0, {(SPEED_W-1){1'b1}}};

  typedef enum logic [1:0] {
    CAUSE_NONE,
    CAUSE_TARGET,
    CAUSE_TIME,
    CAUSE_ROUGH
  } cause_t;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_BASE,
    PH_SPEED,
    PH_ACCEL
  } phase_t;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } iu_op_t;

  typedef struct packed {
    logic   start;
    iu_op_t op;
  } iu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_stat_t;

  typedef struct packed {
    logic [TIME_W-1:0]  time_limit;
    logic [ROUGH_W-1:0] rough_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TIME,
    ST_SPD_DIV,
    ST_SPD_WAIT,
    ST_SPD_SET,
    ST_DV,
    ST_ACC_DIV,
    ST_ACC_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_ROUGH,
    ST_CHECK,
    ST_OUT
  } state_t;

  // dividend width of the shared unit: scaled distance or scaled speed delta
  function automatic int num_width(int dist_bits);
    int w;
    w = dist_bits + FRAC_BITS + 1;
    return (w > ACCEL_W) ? w : ACCEL_W;
  endfunction

endpackage

[rtl/mrm_cfg_regs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrm_cfg_regs
// APB register file: time limit and roughness limit.
// ---------------------------------------------------------------------------
module mrm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mrm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output mrm_pkg::cfg_t                 cfg
);
  import mrm_pkg::*;

  logic [TIME_W-1:0]  time_limit_r;
  logic [ROUGH_W-1:0] rough_limit_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[REG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_limit_r  <= TIME_LIMIT_RST;
      rough_limit_r <= ROUGH_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TIME_LIMIT:  time_limit_r  <= pwdata[TIME_W-1:0];
        REG_ROUGH_LIMIT: rough_limit_r <= pwdata[ROUGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIME_LIMIT:  prdata = PDATA_W'(time_limit_r);
      REG_ROUGH_LIMIT: prdata = PDATA_W'(rough_limit_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{time_limit: time_limit_r, rough_limit: rough_limit_r};

endmodule

[rtl/mrm_iter_unit.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// mrm_iter_unit
// Shared bit-serial unit: restoring divide, or saturating shift-add multiply.
// ---------------------------------------------------------------------------
module mrm_iter_unit #(
  parameter  int DISTANCE_BITS = mrm_pkg::DISTANCE_BITS_DEF,
  parameter  int DELAY_BITS    = mrm_pkg::DELAY_BITS_DEF,
  localparam int NUM_W         = mrm_pkg::num_width(DISTANCE_BITS),
  localparam int DEN_W         = DELAY_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrm_pkg::iu_ctrl_t    ctrl,
  input  logic [NUM_W-1:0]     op_a,
  input  logic [DEN_W-1:0]     op_b,
  output mrm_pkg::iu_stat_t    stat,
  output logic [NUM_W-1:0]     result
);
  import mrm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  iu_op_t             op_r, op_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   sh_r, sh_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [ROUGH_W-1:0] prod_r, prod_nxt;
  logic               over_r, over_nxt;

  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     rem_sub;
  logic               rem_ge;
  logic [ACCEL_W:0]   prod_sum;

  always_comb begin
    rem_sh   = {rem_r, sh_r[NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    rem_ge   = (rem_sh >= {1'b0, den_r});
    prod_sum = {1'b0, prod_r, 1'b0} +
               (den_r[DEN_W-1] ? {1'b0, sh_r[ACCEL_W-1:0]} : {(ACCEL_W+1){1'b0}});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    prod_nxt = prod_r;
    over_nxt = over_r;

    if (ctrl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctrl.op;
      sh_nxt   = op_a;
      den_nxt  = op_b;
      rem_nxt  = '0;
      prod_nxt = '0;
      over_nxt = 1'b0;
      cnt_nxt  = (ctrl.op == OP_DIV) ? CNT_W'(NUM_W) : CNT_W'(DEN_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      unique case (op_r)
        OP_DIV: begin
          rem_nxt = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          sh_nxt  = {sh_r[NUM_W-2:0], rem_ge};
        end
        OP_MUL: begin
          // multiplier MSB first; once past the cap it stays saturated
          den_nxt  = den_r << 1;
          prod_nxt = prod_sum[ROUGH_W-1:0];
          over_nxt = over_r | (prod_sum[ACCEL_W:ROUGH_W] != 2'b00);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
    over_r <= over_nxt;
  end

  assign stat   = '{busy: busy_r, done: done_r};
  assign result = (op_r == OP_MUL) ? NUM_W'(over_r ? ROUGH_MAX : prod_r) : sh_r;

  `ASSERT_IMPL(a_start_when_free, ctrl.start, !busy_r)
  `ASSERT_IMPL(a_idle_count_clear, !busy_r, cnt_r == '0)
  `ASSERT_IMPL(a_done_after_busy, done_r, !busy_r && $past(busy_r))

endmodule

[rtl/motion_roughness_monitor.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// motion_roughness_monitor
// Tracks one move from timed distance samples and ends it on target, time
// limit or integrated acceleration limit.
// ---------------------------------------------------------------------------
// One transaction at a time. A start passes the limit check and output
// steps; a target hit or a sample outside a run goes straight to output; a
// first sample adds the time step; a sample that yields a speed adds the
// speed divide; one that yields an acceleration adds the speed delta, the
// acceleration divide, the multiply and the roughness sum. The bit-serial
// divide/multiply unit, NUM_W = max(DISTANCE_BITS + 17, 64) bits wide, runs
// one bit per cycle: two divisions (speed, acceleration) and one saturating
// multiply (integration step). The result sits in an output register, so a
// new transaction is taken while it waits; a report still stalled when the
// next one is ready holds the block in its output step until it is taken.
module motion_roughness_monitor #(
  parameter int DISTANCE_BITS = mrm_pkg::DISTANCE_BITS_DEF,
  parameter int DELAY_BITS    = mrm_pkg::DELAY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [DISTANCE_BITS-1:0]   in_distance,
  input  logic [DELAY_BITS-1:0]             in_elapsed_us,
  input  logic                              in_target_hit,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_running,
  output logic [1:0]                        out_end_cause,
  output logic [mrm_pkg::TIME_W-1:0]        out_total_time_us,
  output logic [mrm_pkg::ROUGH_W-1:0]       out_roughness,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mrm_pkg::PADDR_W-1:0]       paddr,
  input  logic [mrm_pkg::PDATA_W-1:0]       pwdata,
  output logic [mrm_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import mrm_pkg::*;

  localparam int DB    = DISTANCE_BITS;
  localparam int NUM_W = num_width(DISTANCE_BITS);
  localparam int DEN_W = DELAY_BITS + 1;

  cfg_t               cfg;
  iu_ctrl_t           iu_ctrl;
  iu_stat_t           iu_stat;
  logic [NUM_W-1:0]   iu_a;
  logic [DEN_W-1:0]   iu_b;
  logic [NUM_W-1:0]   iu_res;

  // control state
  state_t             state_r, state_nxt;
  logic               run_active_r, run_active_nxt;
  cause_t             stop_reason_r, stop_reason_nxt;
  phase_t             phase_r, phase_nxt;
  logic [TIME_W-1:0]  time_total_r, time_total_nxt;
  logic [ROUGH_W-1:0] rough_total_r, rough_total_nxt;
  logic               out_valid_r, out_valid_nxt;

  // run history and per-transaction work registers
  logic signed [DB-1:0]     last_dist_r, last_dist_nxt;
  logic [SPEED_W-1:0]       last_speed_r, last_speed_nxt;
  logic [ACCEL_W-1:0]       last_accel_r, last_accel_nxt;
  logic [DELAY_BITS-1:0]    last_delay_r, last_delay_nxt;
  logic signed [DB-1:0]     dist_r, dist_nxt;
  logic [DELAY_BITS-1:0]    delay_r, delay_nxt;
  logic [DB:0]              diff_r, diff_nxt;
  logic [SPEED_W-1:0]       speed_r, speed_nxt;
  logic [SPEED_W:0]         dv_r, dv_nxt;
  logic [ACCEL_W-1:0]       accel_r, accel_nxt;

  logic                     out_running_r, out_running_nxt;
  logic [1:0]               out_cause_r, out_cause_nxt;
  logic [TIME_W-1:0]        out_time_r, out_time_nxt;
  logic [ROUGH_W-1:0]       out_rough_r, out_rough_nxt;

  logic [TIME_W:0]          time_sum;
  logic [DB:0]              diff_mag;
  logic [SPEED_W-1:0]       speed_q;
  logic [SPEED_W-1:0]       speed_sgn;
  logic [SPEED_W:0]         dv_mag;
  logic [ACCEL_W-1:0]       accel_q;
  logic [ACCEL_W-1:0]       mcand;
  logic [ROUGH_W:0]         rough_sum;

  mrm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrm_iter_unit #(
    .DISTANCE_BITS (DISTANCE_BITS),
    .DELAY_BITS    (DELAY_BITS)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (iu_ctrl),
    .op_a   (iu_a),
    .op_b   (iu_b),
    .stat   (iu_stat),
    .result (iu_res)
  );

  always_comb begin
    time_sum  = {1'b0, time_total_r} + (TIME_W+1)'(delay_r);
    diff_mag  = diff_r[DB] ? -diff_r : diff_r;
    speed_q   = (iu_res > NUM_W'(SPEED_MAX)) ? SPEED_MAX : iu_res[SPEED_W-1:0];
    speed_sgn = diff_r[DB] ? -speed_q : speed_q;
    dv_mag    = dv_r[SPEED_W] ? -dv_r : dv_r;
    accel_q   = iu_res[ACCEL_W-1:0];
    // trapezoid: floor of the mean of this and the previous acceleration; the first acceleration of a run is used as is
    mcand     = (phase_r == PH_SPEED) ? accel_q :
                ({1'b0, accel_q[ACCEL_W-1:1]} + {1'b0, last_accel_r[ACCEL_W-1:1]} +
                 ACCEL_W'(accel_q[0] & last_accel_r[0]));
    rough_sum = {1'b0, rough_total_r} + {1'b0, iu_res[ROUGH_W-1:0]};
  end

  always_comb begin
    state_nxt       = state_r;
    run_active_nxt  = run_active_r;
    stop_reason_nxt = stop_reason_r;
    phase_nxt       = phase_r;
    time_total_nxt  = time_total_r;
    rough_total_nxt = rough_total_r;
    out_valid_nxt   = out_valid_r;
    last_dist_nxt   = last_dist_r;
    last_speed_nxt  = last_speed_r;
    last_accel_nxt  = last_accel_r;
    last_delay_nxt  = last_delay_r;
    dist_nxt        = dist_r;
    delay_nxt       = delay_r;
    diff_nxt        = diff_r;
    speed_nxt       = speed_r;
    dv_nxt          = dv_r;
    accel_nxt       = accel_r;
    out_running_nxt = out_running_r;
    out_cause_nxt   = out_cause_r;
    out_time_nxt    = out_time_r;
    out_rough_nxt   = out_rough_r;
    iu_ctrl         = '{start: 1'b0, op: OP_DIV};
    iu_a            = '0;
    iu_b            = '0;
    in_stall        = (state_r != ST_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_START) begin
            time_total_nxt  = '0;
            rough_total_nxt = '0;
            phase_nxt       = PH_EMPTY;
            run_active_nxt  = 1'b1;
            stop_reason_nxt = CAUSE_NONE;
            state_nxt       = ST_CHECK;
          end else if (!run_active_r) begin
            state_nxt = ST_OUT;
          end else if (in_target_hit) begin
            run_active_nxt  = 1'b0;
            stop_reason_nxt = CAUSE_TARGET;
            state_nxt       = ST_OUT;
          end else begin
            dist_nxt  = in_distance;
            delay_nxt = (in_elapsed_us == '0) ? DELAY_BITS'(1) : in_elapsed_us;
            state_nxt = ST_TIME;
          end
        end
      end
      ST_TIME: begin
        time_total_nxt = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
        diff_nxt       = {dist_r[DB-1], dist_r} - {last_dist_r[DB-1], last_dist_r};
        if (phase_r == PH_EMPTY) begin
          phase_nxt      = PH_BASE;
          last_dist_nxt  = dist_r;
          last_delay_nxt = delay_r;
          state_nxt      = ST_CHECK;
        end else begin
          state_nxt = ST_SPD_DIV;
        end
      end
      ST_SPD_DIV: begin
        iu_ctrl   = '{start: 1'b1, op: OP_DIV};
        iu_a      = NUM_W'({diff_mag, {FRAC_BITS{1'b0}}});
        iu_b      = DEN_W'(delay_r);
        state_nxt = ST_SPD_WAIT;
      end
      ST_SPD_WAIT: begin
        if (iu_stat.done) begin
          state_nxt = ST_SPD_SET;
        end
      end
      ST_SPD_SET: begin
        if (phase_r == PH_BASE) begin
          last_speed_nxt = speed_sgn;
          phase_nxt      = PH_SPEED;
          last_dist_nxt  = dist_r;
          last_delay_nxt = delay_r;
          state_nxt      = ST_CHECK;
        end else begin
          speed_nxt = speed_sgn;
          state_nxt = ST_DV;
        end
      end
      ST_DV: begin
        dv_nxt    = {speed_r[SPEED_W-1], speed_r} -
                    {last_speed_r[SPEED_W-1], last_speed_r};
        state_nxt = ST_ACC_DIV;
      end
      ST_ACC_DIV: begin
        iu_ctrl   = '{start: 1'b1, op: OP_DIV};
        iu_a      = NUM_W'({dv_mag[SPEED_W-1:0], {FRAC_BITS{1'b0}}});
        iu_b      = DEN_W'(last_delay_r) + DEN_W'(delay_r);
        state_nxt = ST_ACC_WAIT;
      end
      ST_ACC_WAIT: begin
        if (iu_stat.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        accel_nxt = accel_q;
        iu_ctrl   = '{start: 1'b1, op: OP_MUL};
        iu_a      = NUM_W'(mcand);
        iu_b      = DEN_W'(last_delay_r);
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (iu_stat.done) begin
          state_nxt = ST_ROUGH;
        end
      end
      ST_ROUGH: begin
        rough_total_nxt = rough_sum[ROUGH_W] ? ROUGH_MAX : rough_sum[ROUGH_W-1:0];
        last_accel_nxt  = accel_r;
        last_speed_nxt  = speed_r;
        last_dist_nxt   = dist_r;
        last_delay_nxt  = delay_r;
        phase_nxt       = PH_ACCEL;
        state_nxt       = ST_CHECK;
      end
      ST_CHECK: begin
        if (run_active_r) begin
          if (time_total_r >= cfg.time_limit) begin
            run_active_nxt  = 1'b0;
            stop_reason_nxt = CAUSE_TIME;
          end else if (rough_total_r >= cfg.rough_limit) begin
            run_active_nxt  = 1'b0;
            stop_reason_nxt = CAUSE_ROUGH;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_running_nxt = run_active_r;
          out_cause_nxt   = stop_reason_r;
          out_time_nxt    = time_total_r;
          out_rough_nxt   = rough_total_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      run_active_r  <= 1'b0;
      stop_reason_r <= CAUSE_NONE;
      phase_r       <= PH_EMPTY;
      time_total_r  <= '0;
      rough_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      run_active_r  <= run_active_nxt;
      stop_reason_r <= stop_reason_nxt;
      phase_r       <= phase_nxt;
      time_total_r  <= time_total_nxt;
      rough_total_r <= rough_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_dist_r   <= last_dist_nxt;
    last_speed_r  <= last_speed_nxt;
    last_accel_r  <= last_accel_nxt;
    last_delay_r  <= last_delay_nxt;
    dist_r        <= dist_nxt;
    delay_r       <= delay_nxt;
    diff_r        <= diff_nxt;
    speed_r       <= speed_nxt;
    dv_r          <= dv_nxt;
    accel_r       <= accel_nxt;
    out_running_r <= out_running_nxt;
    out_cause_r   <= out_cause_nxt;
    out_time_r    <= out_time_nxt;
    out_rough_r   <= out_rough_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_running       = out_running_r;
  assign out_end_cause     = out_cause_r;
  assign out_total_time_us = out_time_r;
  assign out_roughness     = out_rough_r;

  `ASSERT_IMPL(a_running_no_cause, run_active_r, stop_reason_r == CAUSE_NONE)
  `ASSERT_IMPL(a_accept_unit_free, !in_stall, !iu_stat.busy)
  `ASSERT_IMPL(a_rough_needs_speed, state_r == ST_ROUGH,
               phase_r == PH_SPEED || phase_r == PH_ACCEL)

endmodule
